### rtl/core/rhht_pkg.sv
// Package for the Robin Hood hash table: sizes, status and operation codes, word types.
// No dependencies.
`default_nettype none
package rhht_pkg;
  localparam int SLOTS = 1024;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int KEY_BITS = 32;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 11;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_DELETED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
    logic [31:0] key_hash;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [31:0]           found_value;
    logic [COUNT_BITS-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic                  used;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    logic [SLOT_BITS-1:0]  home;
  } slot_t;
endpackage
`default_nettype wire

### rtl/core/rhht_if.sv
// Valid/ready channel interfaces for the hash table request and response words.
// Depends on rhht_pkg.
`default_nettype none
interface rhht_req_if;
  logic valid;
  logic ready;
  rhht_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rhht_rsp_if;
  logic valid;
  logic ready;
  rhht_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/robin_hood_hash_table_top.sv
// Robin Hood hash table top level: slot memory with occupancy bits and probe sequencer.
// Depends on rhht_pkg and rhht_if.
//
// Usage: req carries one word per operation (insert/update, find, delete) with key,
// precomputed hash and value; rsp returns one word per request with status,
// found value and the entry count after the operation.
// One operation at a time. Each probe step is a registered read of the slot memory
// followed by a decision on the read word. A request runs the lookup probe, then
// the insert carry walk or the delete back-shift, one probe step per slot touched.
// The next request is taken only once the previous one has moved its response
// word into the output register.
// Occupancy bits live in the slot memory; after rst a clearing pass writes all
// 1024 slots, one per cycle, with req.ready low, so the first request is taken
// only after the clearing pass ends.
// The response sits in an output register; while rsp is stalled the next
// request is taken and its work runs, waiting only to hand off its own word.
`default_nettype none
module robin_hood_hash_table_top (
  input wire clk,
  input wire rst,
  rhht_req_if.sink req,
  rhht_rsp_if.source rsp
);
  import rhht_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_DEL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  slot_t mem [SLOTS];
  slot_t rd;
  logic rd_ok;

  logic [2:0] state;
  logic [1:0] op;
  logic [KEY_BITS-1:0] key;
  logic [VALUE_BITS-1:0] val;
  logic [SLOT_BITS-1:0] home, idx, hole;
  logic [SLOT_BITS:0] pdist, steps;
  logic [COUNT_BITS-1:0] count;
  logic [2:0] status;
  logic [31:0] found;
  logic [2:0] out_status;
  logic [31:0] out_found;
  logic [COUNT_BITS-1:0] out_count;

  logic wr_en;
  logic [SLOT_BITS-1:0] wr_addr;
  slot_t wr_data;

  logic cur_used;
  logic [SLOT_BITS-1:0] rdist, nxt;
  assign cur_used = rd.used;
  assign rdist = idx - rd.home;
  assign nxt = idx + SLOT_BITS'(1);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[idx];
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.data.status = out_status;
  assign rsp.data.found_value = out_found;
  assign rsp.data.entry_count = out_count;

  always_ff @(posedge clk) begin
    wr_en <= 1'b0;
    if (rst) begin
      state <= S_CLR;
      idx <= '0;
      count <= '0;
      rsp.valid <= 1'b0;
      rd_ok <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          wr_en <= 1'b1; wr_addr <= idx; wr_data <= '0;
          idx <= nxt;
          if (idx == SLOT_BITS'(SLOTS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (req.valid) begin
          op <= req.data.operation;
          key <= KEY_BITS'(req.data.key);
          val <= VALUE_BITS'(req.data.value);
          home <= req.data.key_hash[SLOT_BITS-1:0];
          idx <= req.data.key_hash[SLOT_BITS-1:0];
          pdist <= '0;
          steps <= '0;
          rd_ok <= 1'b0;
          found <= '0;
          status <= ST_NOT_FOUND;
          state <= S_LOOK;
        end
        S_LOOK: begin
          rd_ok <= ~rd_ok;
          if (rd_ok) begin
            if (cur_used && steps != (SLOT_BITS+1)'(SLOTS) && rd.key == key) begin
              state <= S_DONE;
              if (op == OP_INSERT) begin
                wr_en <= 1'b1; wr_addr <= idx;
                wr_data <= '{used: 1'b1, key: rd.key, value: val, home: rd.home};
                status <= ST_UPDATED;
              end else if (op == OP_FIND) begin
                found <= 32'(rd.value);
                status <= ST_FOUND;
              end else if (op == OP_DELETE) begin
                status <= ST_DELETED;
                hole <= idx;
                idx <= nxt;
                steps <= (SLOT_BITS+1)'(1);
                state <= S_DEL;
              end
            end else if (!cur_used || steps == (SLOT_BITS+1)'(SLOTS) ||
                         {1'b0, rdist} < pdist) begin
              // miss
              if (op == OP_INSERT) begin
                if (count >= COUNT_BITS'(SLOTS)) begin
                  status <= ST_FULL;
                  state <= S_DONE;
                end else begin
                  status <= ST_INSERTED;
                  idx <= home;
                  pdist <= '0;
                  steps <= '0;
                  state <= S_INS;
                end
              end else state <= S_DONE;
            end else begin
              idx <= nxt; pdist <= pdist + 1'b1; steps <= steps + 1'b1;
            end
          end
        end
        S_INS: begin
          rd_ok <= ~rd_ok;
          if (rd_ok) begin
            if (!cur_used) begin
              wr_en <= 1'b1; wr_addr <= idx;
              wr_data <= '{used: 1'b1, key: key, value: val, home: home};
              count <= count + 1'b1;
              state <= S_DONE;
            end else begin
              if ({1'b0, rdist} < pdist) begin
                wr_en <= 1'b1; wr_addr <= idx;
                wr_data <= '{used: 1'b1, key: key, value: val, home: home};
                key <= rd.key; val <= rd.value; home <= rd.home;
                pdist <= {1'b0, rdist} + 1'b1;
              end else pdist <= pdist + 1'b1;
              idx <= nxt;
            end
          end
        end
        S_DEL: begin
          rd_ok <= ~rd_ok;
          if (rd_ok) begin
            if (!cur_used || rdist == '0 || steps == (SLOT_BITS+1)'(SLOTS)) begin
              wr_en <= 1'b1; wr_addr <= hole; wr_data <= '0;
              count <= count - 1'b1;
              state <= S_DONE;
            end else begin
              wr_en <= 1'b1; wr_addr <= hole; wr_data <= rd;
              hole <= idx; idx <= nxt; steps <= steps + 1'b1;
            end
          end
        end
        S_DONE: if (!rsp.valid || rsp.ready) begin
          rsp.valid <= 1'b1;
          out_status <= status;
          out_found <= found;
          out_count <= count;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(SLOTS)) else $error("count overflow");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && (!rsp.valid || rsp.ready) |=> rsp.valid)
    else $error("response lost");
  a_full_nochange: assert property (@(posedge clk) disable iff (rst)
    state == S_INS |-> count < COUNT_BITS'(SLOTS)) else $error("insert into full table");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $past(rd_ok) || $past(state == S_CLR)) else $error("write without read");
endmodule
`default_nettype wire
